### rtl/pstbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstbp_pkg: shared types and constants
// field widths, defaults, divider sizing and the controller/datapath bundles
// ----------------------------------------------------------------------------
package pstbp_pkg;

  localparam int RATE_W  = 37;
  localparam int BURST_W = 32;
  localparam int TIME_W  = 64;
  localparam int LEN_W   = 16;
  localparam int KEY_W   = 32;
  localparam int ETYPE_W = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST = 1'b1;

  localparam logic [ETYPE_W-1:0] IPV4_TYPE     = 16'h0800;
  localparam logic [RATE_W-1:0]  DEFAULT_RATE  = 37'd200000000;
  localparam logic [BURST_W-1:0] DEFAULT_BURST = 32'd1250000;

  // elapsed time is capped at one second, which fits 30 bits
  localparam int DELTA_W = 30;
  localparam logic [DELTA_W-1:0] NS_PER_SEC = 30'd1000000000;

  // rate/8 is 34 bits, split into two 17 bit halves for the multiplier
  localparam int RATE8_W = RATE_W - 3;
  localparam int HALF_W  = RATE8_W / 2;
  localparam int PART_W  = HALF_W + DELTA_W;
  localparam int PROD_W  = 64;

  // quotient < 2^36, so the top 28 product bits form the first remainder
  localparam int Q_W        = 36;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = Q_W / DIV_BITS;
  localparam int DIV_CNT_W  = 4;
  localparam int REM_W      = DELTA_W;

  typedef struct packed {
    logic capture;
    logic look;
    logic upd;
    logic load;
    logic cap;
    logic mlo;
    logic mhi;
    logic sum;
    logic div_step;
    logic add;
    logic fin;
    logic out_load;
  } pstbp_cmd_t;

  typedef struct packed {
    logic bypass;
  } pstbp_stat_t;

endpackage
`default_nettype wire

### rtl/per_source_token_bucket_policer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// a table word goes through lookup, bucket read, elapsed time, multiply, divide, update and output;
//   the divide by 1e9 makes 4 bits/cycle, and the input is stalled from accept until the verdict
//   is loaded into the output register, so a new word is taken only after the last one is loaded
// bypassed (non-ipv4 or truncated) words skip the table and go from accept straight to output
// reset: synchronous, active low; clears valid bits, lru ages to index order,
//   config registers, sequencer and out_valid; no clearing pass is needed
// ----------------------------------------------------------------------------
// per_source_token_bucket_policer_unit: per source address token bucket policer
// fully associative lru table of buckets, refilled from elapsed time at rate/8
// ----------------------------------------------------------------------------
module per_source_token_bucket_policer_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration writes
  input  wire                               cfg_we,
  input  wire  [pstbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pstbp_pkg::RATE_W-1:0]      cfg_wdata,
  // packet descriptor word
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [pstbp_pkg::ETYPE_W-1:0]     in_ether_type,
  input  wire                               in_headers_present,
  input  wire  [pstbp_pkg::KEY_W-1:0]       in_source_addr,
  input  wire  [pstbp_pkg::LEN_W-1:0]       in_packet_bytes,
  input  wire  [pstbp_pkg::TIME_W-1:0]      in_now_ns,
  // verdict word
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_verdict,
  output logic                              out_new_flow,
  output logic [pstbp_pkg::BURST_W-1:0]     out_tokens_left
);

  // sequencer to datapath commands, datapath bypass status back
  pstbp_pkg::pstbp_cmd_t  cmd;
  pstbp_pkg::pstbp_stat_t stat;

  // the sequencer owns the handshakes; the output register in the datapath
  // lets a new word be taken while the previous verdict is still stalled
  pstbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key cam, lru ages, bucket memory and refill arithmetic
  pstbp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_ether_type      (in_ether_type),
    .in_headers_present (in_headers_present),
    .in_source_addr     (in_source_addr),
    .in_packet_bytes    (in_packet_bytes),
    .in_now_ns          (in_now_ns),
    .out_verdict        (out_verdict),
    .out_new_flow       (out_new_flow),
    .out_tokens_left    (out_tokens_left)
  );

endmodule
`default_nettype wire

### rtl/pstbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstbp_ctrl: policer sequencer
// steps one packet word through lookup, refill arithmetic and output
// ----------------------------------------------------------------------------
module pstbp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  pstbp_pkg::pstbp_stat_t stat,
  output pstbp_pkg::pstbp_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_LOAD = 4'd3;
  localparam logic [3:0] S_CAP  = 4'd4;
  localparam logic [3:0] S_MLO  = 4'd5;
  localparam logic [3:0] S_MHI  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [pstbp_pkg::DIV_CNT_W-1:0] DIV_LAST =
    pstbp_pkg::DIV_CNT_W'(pstbp_pkg::DIV_STEPS - 1);

  logic [3:0] state_r, state_nxt;
  logic [pstbp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.bypass ? S_OUT : S_LOOK;
        end
      end
      S_LOOK: begin cmd.look = 1'b1; state_nxt = S_UPD; end
      S_UPD:  begin cmd.upd  = 1'b1; state_nxt = S_LOAD; end
      S_LOAD: begin cmd.load = 1'b1; state_nxt = S_CAP; end
      S_CAP:  begin cmd.cap  = 1'b1; state_nxt = S_MLO; end
      S_MLO:  begin cmd.mlo  = 1'b1; state_nxt = S_MHI; end
      S_MHI:  begin cmd.mhi  = 1'b1; state_nxt = S_SUM; end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:  begin cmd.add = 1'b1; state_nxt = S_FIN; end
      S_FIN:  begin cmd.fin = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == DIV_LAST) |=> state_r == S_ADD)
    else $error("divider did not finish after its last step");
  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result shown outside output state");
  a_bypass_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stat.bypass) |=> state_r == S_OUT)
    else $error("bypassed word entered table path");

endmodule
`default_nettype wire

### rtl/pstbp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstbp_dp: policer datapath
// key cam, lru ages, bucket memory, refill multiplier and radix-16 divider
// ----------------------------------------------------------------------------
module pstbp_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  pstbp_pkg::pstbp_cmd_t                 cmd,
  output pstbp_pkg::pstbp_stat_t                stat,
  input  wire                                   cfg_we,
  input  wire  [pstbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [pstbp_pkg::RATE_W-1:0]          cfg_wdata,
  input  wire  [pstbp_pkg::ETYPE_W-1:0]         in_ether_type,
  input  wire                                   in_headers_present,
  input  wire  [pstbp_pkg::KEY_W-1:0]           in_source_addr,
  input  wire  [pstbp_pkg::LEN_W-1:0]           in_packet_bytes,
  input  wire  [pstbp_pkg::TIME_W-1:0]          in_now_ns,
  output logic                                  out_verdict,
  output logic                                  out_new_flow,
  output logic [pstbp_pkg::BURST_W-1:0]         out_tokens_left
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int WORD_W = pstbp_pkg::BURST_W + pstbp_pkg::TIME_W;
  localparam logic [IDX_W-1:0] AGE_OLDEST = IDX_W'(TABLE_ENTRIES - 1);

  // configuration
  logic [pstbp_pkg::RATE_W-1:0]  rate_cfg_r;
  logic [pstbp_pkg::BURST_W-1:0] burst_cfg_r;
  logic [pstbp_pkg::RATE_W-1:0]  rate_eff;
  logic [pstbp_pkg::BURST_W-1:0] burst_eff;
  logic [pstbp_pkg::RATE8_W-1:0] rate8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_cfg_r  <= '0;
      burst_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pstbp_pkg::REG_RATE:  rate_cfg_r  <= cfg_wdata;
        pstbp_pkg::REG_BURST: burst_cfg_r <= cfg_wdata[pstbp_pkg::BURST_W-1:0];
        default: ;
      endcase
    end
  end

  assign rate_eff  = (rate_cfg_r == '0) ? pstbp_pkg::DEFAULT_RATE : rate_cfg_r;
  assign burst_eff = (burst_cfg_r == '0) ? pstbp_pkg::DEFAULT_BURST : burst_cfg_r;
  assign rate8     = rate_eff[pstbp_pkg::RATE_W-1:3];

  assign stat.bypass = !in_headers_present || (in_ether_type != pstbp_pkg::IPV4_TYPE);

  // captured word
  logic [pstbp_pkg::KEY_W-1:0]  key_r;
  logic [pstbp_pkg::LEN_W-1:0]  len_r;
  logic [pstbp_pkg::TIME_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r <= in_source_addr;
      len_r <= in_packet_bytes;
      now_r <= in_now_ns;
    end
  end

  // lookup: cam compare and lru victim
  logic [pstbp_pkg::KEY_W-1:0] ekey_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    evalid_r;
  logic [IDX_W-1:0]            age_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    hit_vec, victim_vec;
  logic [TABLE_ENTRIES-1:0]    sel_vec_r;
  logic [IDX_W-1:0]            slot_r, slot_enc, sel_age;
  logic                        miss_r;

  always_comb begin
    slot_enc = '0;
    sel_age  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]    = evalid_r[i] && (ekey_r[i] == key_r);
      victim_vec[i] = (age_r[i] == AGE_OLDEST);
      if (sel_vec_r[i]) begin
        sel_age = sel_age | age_r[i];
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if ((|hit_vec) ? hit_vec[i] : victim_vec[i]) begin
        slot_enc = slot_enc | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      sel_vec_r <= (|hit_vec) ? hit_vec : victim_vec;
      slot_r    <= slot_enc;
      miss_r    <= !(|hit_vec);
    end
  end

  // entry update: most recent gets age zero, younger ones age by one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evalid_r <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        age_r[i] <= IDX_W'(i);
      end
    end else if (cmd.upd) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (sel_vec_r[i]) begin
          age_r[i] <= '0;
          if (miss_r) begin
            evalid_r[i] <= 1'b1;
          end
        end else if (age_r[i] < sel_age) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd.upd && sel_vec_r[i] && miss_r) begin
        ekey_r[i] <= key_r;
      end
    end
  end

  // bucket memory: tokens and last time
  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rd_r;
  logic [pstbp_pkg::BURST_W-1:0] tok_fin;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rd_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      mem[slot_r] <= {tok_fin, now_r};
    end
  end

  // elapsed time
  logic [pstbp_pkg::BURST_W-1:0] tok_r;
  logic [pstbp_pkg::TIME_W-1:0]  draw_r;
  logic [pstbp_pkg::DELTA_W-1:0] delta_r;
  logic [pstbp_pkg::TIME_W-1:0]  last_sel;

  assign last_sel = miss_r ? now_r : rd_r[pstbp_pkg::TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_r  <= miss_r ? burst_eff : rd_r[WORD_W-1:pstbp_pkg::TIME_W];
      draw_r <= now_r - last_sel;
    end
    if (cmd.cap) begin
      delta_r <= (draw_r > pstbp_pkg::TIME_W'(pstbp_pkg::NS_PER_SEC)) ?
                 pstbp_pkg::NS_PER_SEC : draw_r[pstbp_pkg::DELTA_W-1:0];
    end
  end

  // refill product over two multiplier passes
  logic [pstbp_pkg::HALF_W-1:0] mul_a;
  logic [pstbp_pkg::PART_W-1:0] mul_p, plo_r, phi_r;
  logic [pstbp_pkg::PROD_W-1:0] prod;

  assign mul_a = cmd.mhi ? rate8[pstbp_pkg::RATE8_W-1:pstbp_pkg::HALF_W]
                         : rate8[pstbp_pkg::HALF_W-1:0];
  assign mul_p = pstbp_pkg::PART_W'(mul_a) * pstbp_pkg::PART_W'(delta_r);
  assign prod  = {phi_r[pstbp_pkg::PROD_W-pstbp_pkg::HALF_W-1:0],
                  {pstbp_pkg::HALF_W{1'b0}}} + pstbp_pkg::PROD_W'(plo_r);

  always_ff @(posedge clk) begin
    if (cmd.mlo) begin
      plo_r <= mul_p;
    end
    if (cmd.mhi) begin
      phi_r <= mul_p;
    end
  end

  // divide by one second, four quotient bits a cycle
  logic [pstbp_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [pstbp_pkg::Q_W-1:0]   dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [pstbp_pkg::REM_W:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int j = 0; j < pstbp_pkg::DIV_BITS; j++) begin
      trial   = {rem_nxt, dvd_nxt[pstbp_pkg::Q_W-1]};
      dvd_nxt = {dvd_nxt[pstbp_pkg::Q_W-2:0], 1'b0};
      if (trial >= {1'b0, pstbp_pkg::NS_PER_SEC}) begin
        trial   = trial - {1'b0, pstbp_pkg::NS_PER_SEC};
        quo_nxt = {quo_nxt[pstbp_pkg::Q_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[pstbp_pkg::Q_W-2:0], 1'b0};
      end
      rem_nxt = trial[pstbp_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rem_r <= pstbp_pkg::REM_W'(prod[pstbp_pkg::PROD_W-1:pstbp_pkg::Q_W]);
      dvd_r <= prod[pstbp_pkg::Q_W-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
    end
  end

  // add refill, clamp, charge the packet
  logic [pstbp_pkg::Q_W:0]       tok_sum;
  logic [pstbp_pkg::BURST_W-1:0] tok_c_r;
  logic                          short_fin;
  logic                          res_verdict_r, res_new_r;
  logic [pstbp_pkg::BURST_W-1:0] res_tok_r;

  assign tok_sum   = (pstbp_pkg::Q_W+1)'(tok_r) + (pstbp_pkg::Q_W+1)'(quo_r);
  assign short_fin = tok_c_r < pstbp_pkg::BURST_W'(len_r);
  assign tok_fin   = short_fin ? tok_c_r : tok_c_r - pstbp_pkg::BURST_W'(len_r);

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      tok_c_r <= (tok_sum > (pstbp_pkg::Q_W+1)'(burst_eff)) ? burst_eff
                 : tok_sum[pstbp_pkg::BURST_W-1:0];
    end
    if (cmd.capture) begin
      res_verdict_r <= 1'b0;
      res_new_r     <= 1'b0;
      res_tok_r     <= '0;
    end else if (cmd.fin) begin
      res_verdict_r <= short_fin;
      res_new_r     <= miss_r;
      res_tok_r     <= tok_fin;
    end
    if (cmd.out_load) begin
      out_verdict     <= res_verdict_r;
      out_new_flow    <= res_new_r;
      out_tokens_left <= res_tok_r;
    end
  end

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> $onehot(sel_vec_r))
    else $error("lookup selected no entry or several");
  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.look |-> $onehot(victim_vec))
    else $error("lru ages are not a permutation");
  a_delta_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mlo |-> delta_r <= pstbp_pkg::NS_PER_SEC)
    else $error("elapsed time above one second");

endmodule
`default_nettype wire

### verif/per_source_token_bucket_policer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_token_bucket_policer_unit_test: self-checking bench for the policer
// packet descriptors go in from a queue with random gaps and verdicts are drained
// with random stalls; each accepted word is run through an lru token bucket
// predictor and the verdict words are compared in order, field by field
// ----------------------------------------------------------------------------
module per_source_token_bucket_policer_unit_test;

  localparam int ENTRIES = 16;
  localparam int POOL_N = 24;
  localparam longint unsigned BILLION = 64'd1000000000;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [pstbp_pkg::ETYPE_W-1:0] ether_type;
    logic                          headers_present;
    logic [pstbp_pkg::KEY_W-1:0]   source_addr;
    logic [pstbp_pkg::LEN_W-1:0]   packet_bytes;
    logic [pstbp_pkg::TIME_W-1:0]  now_ns;
  } pkt_t;

  typedef struct packed {
    logic                          verdict;
    logic                          new_flow;
    logic [pstbp_pkg::BURST_W-1:0] tokens_left;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pstbp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pstbp_pkg::RATE_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [pstbp_pkg::ETYPE_W-1:0] in_ether_type;
  logic in_headers_present;
  logic [pstbp_pkg::KEY_W-1:0] in_source_addr;
  logic [pstbp_pkg::LEN_W-1:0] in_packet_bytes;
  logic [pstbp_pkg::TIME_W-1:0] in_now_ns;
  logic out_valid;
  logic out_stall;
  logic out_verdict;
  logic out_new_flow;
  logic [pstbp_pkg::BURST_W-1:0] out_tokens_left;

  per_source_token_bucket_policer_unit #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ether_type(in_ether_type), .in_headers_present(in_headers_present),
    .in_source_addr(in_source_addr), .in_packet_bytes(in_packet_bytes),
    .in_now_ns(in_now_ns),
    .out_valid(out_valid), .out_stall(out_stall), .out_verdict(out_verdict),
    .out_new_flow(out_new_flow), .out_tokens_left(out_tokens_left)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // packets waiting to be driven and verdicts waiting to come back
  pkt_t     pkt_q[$];
  verdict_t verdict_q[$];
  int       errs = 0;
  bit       no_idle = 0;

  // predictor copy of the configuration and the bucket table
  logic [pstbp_pkg::RATE_W-1:0]  rate_reg;
  logic [pstbp_pkg::BURST_W-1:0] burst_reg;
  logic [pstbp_pkg::KEY_W-1:0]   bkt_key[ENTRIES];
  logic [31:0]                   bkt_tokens[ENTRIES];
  logic [63:0]                   bkt_stamp[ENTRIES];
  bit                            bkt_used[ENTRIES];
  int                            bkt_age[ENTRIES];

  function automatic verdict_t police(pkt_t p);
    verdict_t v;
    logic [63:0] rate, burst, delta, tokens;
    int slot;
    int oldest;
    bit hit;
    v = '0;
    slot = 0;
    hit = 0;
    rate = (rate_reg != 0) ? 64'(rate_reg) : 64'(pstbp_pkg::DEFAULT_RATE);
    burst = (burst_reg != 0) ? 64'(burst_reg) : 64'(pstbp_pkg::DEFAULT_BURST);
    // non-ipv4 or truncated frames pass without touching the table
    if (!p.headers_present || p.ether_type != pstbp_pkg::IPV4_TYPE) return v;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit && bkt_used[i] && bkt_key[i] == p.source_addr) begin
        slot = i;
        hit = 1;
      end
    end
    if (!hit) begin
      // evict the least recently used bucket, refill it full
      for (int i = 0; i < ENTRIES; i++)
        if (bkt_age[i] == ENTRIES - 1) slot = i;
      bkt_used[slot] = 1;
      bkt_key[slot] = p.source_addr;
      bkt_tokens[slot] = burst[31:0];
      bkt_stamp[slot] = p.now_ns;
      v.new_flow = 1;
    end
    oldest = bkt_age[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (bkt_age[i] < oldest) bkt_age[i]++;
    bkt_age[slot] = 0;
    // wrapping elapsed time, capped at one second
    delta = p.now_ns - bkt_stamp[slot];
    if (delta > BILLION) delta = BILLION;
    tokens = 64'(bkt_tokens[slot]) + ((rate >> 3) * delta) / BILLION;
    if (tokens > burst) tokens = burst;
    bkt_stamp[slot] = p.now_ns;
    if (tokens < 64'(p.packet_bytes)) v.verdict = 1;
    else tokens -= 64'(p.packet_bytes);
    bkt_tokens[slot] = tokens[31:0];
    v.tokens_left = tokens[31:0];
    return v;
  endfunction

  // driver: one descriptor word at a time, random gap after each
  int gap_left;
  always @(posedge clk) begin
    pkt_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        verdict_q.push_back(police({in_ether_type, in_headers_present, in_source_addr,
                                    in_packet_bytes, in_now_ns}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pkt_q.size() > 0) begin
        p = pkt_q.pop_front();
        in_ether_type <= p.ether_type;
        in_headers_present <= p.headers_present;
        in_source_addr <= p.source_addr;
        in_packet_bytes <= p.packet_bytes;
        in_now_ns <= p.now_ns;
        in_valid <= 1'b1;
        gap_left <= no_idle ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random stall per word, one long hold-off to back up the block
  int stall_left;
  int words_seen;
  always @(posedge clk) begin
    verdict_t want;
    int next_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      words_seen <= 0;
    end else begin
      next_stall = (stall_left > 0) ? stall_left - 1 : 0;
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (verdict_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected verdict word v=%0d n=%0d t=%0d", $time,
                   out_verdict, out_new_flow, out_tokens_left);
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict) begin
            errs++;
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict, out_verdict);
          end
          if (out_new_flow !== want.new_flow) begin
            errs++;
            $display("%0t: new_flow expected %0d got %0d", $time, want.new_flow,
                     out_new_flow);
          end
          if (out_tokens_left !== want.tokens_left) begin
            errs++;
            $display("%0t: tokens_left expected %0d got %0d", $time, want.tokens_left,
                     out_tokens_left);
          end
        end
        if (words_seen == 300) next_stall = 600;
        else next_stall = no_idle ? 0 : $urandom_range(0, 8);
      end
      stall_left <= next_stall;
      out_stall <= (next_stall != 0);
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("per_source_token_bucket_policer_unit_test NOT OK");
      $finish;
    end
  end

  logic [pstbp_pkg::KEY_W-1:0] src_pool[POOL_N];
  logic [63:0] clock_ns;

  task automatic add_pkt(logic [15:0] et, logic hp, logic [31:0] key, logic [15:0] len,
                         logic [63:0] now);
    pkt_q.push_back({et, hp, key, len, now});
  endtask

  task automatic write_regs(logic [pstbp_pkg::RATE_W-1:0] rate,
                            logic [pstbp_pkg::BURST_W-1:0] burst);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pstbp_pkg::REG_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= pstbp_pkg::REG_BURST;
    cfg_wdata <= pstbp_pkg::RATE_W'(burst);
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_reg = rate;
    burst_reg = burst;
  endtask

  // wait for every verdict, then the block's latency before touching config;
  // checked between edges so the driver's updates are settled
  task automatic drain();
    while (pkt_q.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic random_traffic(int n, int max_step);
    logic [15:0] et, len;
    logic hp;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      et = pstbp_pkg::IPV4_TYPE;
      hp = 1'b1;
      if (r < 6) begin
        et = 16'($urandom);
        hp = 1'($urandom);
      end else if (r < 9) begin
        hp = 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      r = $urandom_range(0, 99);
      // mostly small forward steps, sometimes huge jumps (backwards and wraps)
      if (r < 3) clock_ns = {$urandom, $urandom};
      else clock_ns += 64'($urandom_range(0, max_step));
      add_pkt(et, hp, src_pool[$urandom_range(0, POOL_N - 1)], len, clock_ns);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ether_type = '0;
    in_headers_present = 1'b0;
    in_source_addr = '0;
    in_packet_bytes = '0;
    in_now_ns = '0;
    rate_reg = '0;
    burst_reg = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      bkt_used[i] = 0;
      bkt_age[i] = i;
      bkt_key[i] = '0;
      bkt_tokens[i] = '0;
      bkt_stamp[i] = '0;
    end
    for (int i = 0; i < POOL_N; i++) src_pool[i] = $urandom;
    clock_ns = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bypass cases, field extremes, wrap and backwards time, defaults
    add_pkt(16'h86DD, 1'b1, 32'h0A000001, 16'd100, 64'd0);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b0, 32'h0A000001, 16'd100, 64'd0);
    add_pkt(16'hFFFF, 1'b0, 32'hFFFFFFFF, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'd0, 64'd0);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'hFFFFFFFF, 16'd1000, 64'd10);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'hFFFF, 64'd5000);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'd1, 64'd3);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'd1, 64'd2000000003);
    drain();

    // small bucket, slow rate: many drops and evictions
    write_regs(37'd8000, 32'd3000);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'd2999, 64'd2000000004);
    add_pkt(pstbp_pkg::IPV4_TYPE, 1'b1, 32'h00000000, 16'd3001, 64'd2000000005);
    random_traffic(200, 400000);
    drain();

    // extremes of both registers, no idling on either side
    write_regs({pstbp_pkg::RATE_W{1'b1}}, 32'hFFFFFFFF);
    no_idle = 1;
    random_traffic(150, 2000);
    drain();
    no_idle = 0;

    // high rate with a tiny bucket, lowering the burst on old buckets
    write_regs(37'd100000000000, 32'd1500);
    random_traffic(250, 50);
    drain();

    // back to defaults through zero writes
    write_regs('0, '0);
    random_traffic(300, 200000);
    drain();

    if (errs == 0) begin
      $display("per_source_token_bucket_policer_unit_test OK");
    end else begin
      $display("per_source_token_bucket_policer_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pstbp_pkg.sv
rtl/pstbp_ctrl.sv
rtl/pstbp_dp.sv
rtl/per_source_token_bucket_policer_unit.sv
verif/per_source_token_bucket_policer_unit_test.sv
